### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### hw/rtl/rbg_pkg.sv
// Shared types, constants and field layout for the range/bearing point converter.
package rbg_pkg;

    localparam int NUM_SENSORS   = 4;
    localparam int BUFFER_POINTS = 64;
    localparam int CNT_W         = $clog2(BUFFER_POINTS + 1);
    localparam int SENS_AW       = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    // Quarter-wave sine table, entries 0..16384 inclusive, Q0.15 magnitudes
    localparam int SINE_W     = 15;
    localparam int SINE_DEPTH = 16385;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam logic [SINE_AW-1:0] SINE_LAST = SINE_AW'(SINE_DEPTH - 1);

    localparam logic [15:0] MAX_RANGE_RESET = 16'd800;

    // Table generator arithmetic (Q30)
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Reciprocals for exact floor division by small constants
    localparam logic [29:0] RECIP_9  = 30'((64'd1 << 33) / 64'd9 + 64'd1);
    localparam logic [31:0] RECIP_21 = 32'((64'd1 << 36) / 64'd21 + 64'd1);
    localparam logic [30:0] RECIP_5  = 31'((64'd1 << 33) / 64'd5 + 64'd1);
    localparam logic [31:0] RECIP_3  = 32'((64'd1 << 33) / 64'd3 + 64'd1);
    localparam logic [22:0] RECIP_45 = 23'((64'd1 << 28) / 64'd45 + 64'd1);

    typedef enum logic {
        FUNC_SCAN  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    // Table fill write port plus completion flag
    typedef struct packed {
        logic               done;
        logic               wr_en;
        logic [SINE_AW-1:0] addr;
        logic [SINE_W-1:0]  data;
    } fill_t;

endpackage

### hw/rtl/rbg_ram.sv
// Generic RAM: one write port, two registered read ports with a shared enable.
module rbg_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16385
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### hw/rtl/rbg_sine_fill.sv
// Pipelined quarter-wave sine generator that fills the sine table after reset.
module rbg_sine_fill (
    input  logic           clk,
    input  logic           rst_n,
    output rbg_pkg::fill_t fill
);

    localparam int FILL_STAGES = 11;

    logic                        gen_busy_reg;
    logic [rbg_pkg::SINE_AW-1:0] r_reg;
    logic [FILL_STAGES-1:0]      vld_reg;
    logic [rbg_pkg::SINE_AW-1:0] wr_addr_reg;
    logic                        done_reg;

    logic [30:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, x6_reg, x7_reg, x8_reg, x9_reg;
    logic [31:0] xx2_reg, xx3_reg, xx4_reg, xx5_reg, xx6_reg, xx7_reg;
    logic [25:0] qa3_reg;
    logic [31:0] pa4_reg;
    logic [26:0] qb5_reg;
    logic [31:0] pb6_reg;
    logic [27:0] qc7_reg;
    logic [31:0] pc8_reg;
    logic [29:0] qd9_reg;
    logic [30:0] s10_reg;
    logic [rbg_pkg::SINE_W-1:0] v11_reg;

    logic [46:0] prod_x;
    logic [61:0] prod_xx;
    logic [58:0] prod_qa;
    logic [30:0] ta, tb, tc, td;
    logic [62:0] prod_pa, prod_pb, prod_pc;
    logic [62:0] prod_qb;
    logic [60:0] prod_qc;
    logic [62:0] prod_qd;
    logic [61:0] prod_s;
    logic [45:0] prod_v;
    logic [15:0] v_round;

    always_comb
    begin
        prod_x  = 47'(r_reg) * 47'(rbg_pkg::PI_Q30);
        prod_xx = 62'(x1_reg) * 62'(x1_reg);
        prod_qa = 59'(xx2_reg[31:3]) * 59'(rbg_pkg::RECIP_9);
        ta      = rbg_pkg::Q30_ONE - 31'(qa3_reg);
        prod_pa = 63'(xx3_reg) * 63'(ta);
        prod_qb = 63'(pa4_reg[31:1]) * 63'(rbg_pkg::RECIP_21);
        tb      = rbg_pkg::Q30_ONE - 31'(qb5_reg);
        prod_pb = 63'(xx5_reg) * 63'(tb);
        prod_qc = 61'(pb6_reg[31:2]) * 61'(rbg_pkg::RECIP_5);
        tc      = rbg_pkg::Q30_ONE - 31'(qc7_reg);
        prod_pc = 63'(xx7_reg) * 63'(tc);
        prod_qd = 63'(pc8_reg[31:1]) * 63'(rbg_pkg::RECIP_3);
        td      = rbg_pkg::Q30_ONE - 31'(qd9_reg);
        prod_s  = 62'(x9_reg) * 62'(td);
        prod_v  = 46'(s10_reg) * 46'(32767) + 46'(1 << 29);
        v_round = prod_v[45:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_busy_reg <= 1'b1;
            r_reg        <= '0;
            vld_reg      <= '0;
            wr_addr_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[FILL_STAGES-2:0], gen_busy_reg};
            if (gen_busy_reg)
            begin
                if (r_reg == rbg_pkg::SINE_LAST)
                begin
                    gen_busy_reg <= 1'b0;
                end
                else
                begin
                    r_reg <= r_reg + 1'b1;
                end
            end
            if (vld_reg[FILL_STAGES-1] && !done_reg)
            begin
                if (wr_addr_reg == rbg_pkg::SINE_LAST)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    wr_addr_reg <= wr_addr_reg + 1'b1;
                end
            end
        end
    end

    // Polynomial pipeline: x, x^2, then nested 1 - x^2/(n(n+1)) terms
    always_ff @(posedge clk)
    begin
        x1_reg  <= prod_x[45:15];
        x2_reg  <= x1_reg;
        xx2_reg <= prod_xx[61:30];
        x3_reg  <= x2_reg;
        xx3_reg <= xx2_reg;
        qa3_reg <= prod_qa[58:33];
        x4_reg  <= x3_reg;
        xx4_reg <= xx3_reg;
        pa4_reg <= prod_pa[61:30];
        x5_reg  <= x4_reg;
        xx5_reg <= xx4_reg;
        qb5_reg <= prod_qb[62:36];
        x6_reg  <= x5_reg;
        xx6_reg <= xx5_reg;
        pb6_reg <= prod_pb[61:30];
        x7_reg  <= x6_reg;
        xx7_reg <= xx6_reg;
        qc7_reg <= prod_qc[60:33];
        x8_reg  <= x7_reg;
        pc8_reg <= prod_pc[61:30];
        x9_reg  <= x8_reg;
        qd9_reg <= prod_qd[62:33];
        s10_reg <= prod_s[60:30];
        v11_reg <= v_round[15] ? {rbg_pkg::SINE_W{1'b1}} : v_round[14:0];
    end

    assign fill.done  = done_reg;
    assign fill.wr_en = vld_reg[FILL_STAGES-1] && !done_reg;
    assign fill.addr  = wr_addr_reg;
    assign fill.data  = v11_reg;

endmodule

### hw/rtl/range_bearing_to_global_points.sv
// Top level: scan beats in, global obstacle points out, one point per cycle.
//
// Usage:
//   s_* carries scan and control beats; tuser is the function (scan or clear
//   fill counts). m_* carries one beat per accepted range, in sensor order,
//   with tlast on the final point of a scan. cfg_* writes max_range and is
//   always ready.
//   After reset the sine table is built by a sweep of 16385 writes plus an
//   11-stage generator pipeline; s_tready stays low until the fill is done.
//   Fill counts reset to zero and max_range to 800.
//   A scan beat's first point passes the input register, then issue and table
//   read, multiply and the output register before it shows on m_tvalid.
//   Throughput: a scan with accepted ranges holds the issue stage until its last
//   point issues (a scan with none, or a clear beat, never enters it); the next
//   beat is taken in the cycle the last point issues. Two dual-read table reads
//   a cycle (sine, cosine) set the one-point-per-cycle figure unless stalled.
//   When a point waits with m_tready low the whole point pipeline holds; one
//   further scan beat is still taken into the input register if it is empty.
module range_bearing_to_global_points (
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata: servo_angle_deg[8:0], heading[24:9], pose_x[44:25], pose_y[64:45],
    //          range_0[80:65], range_1[96:81], range_2[112:97], range_3[128:113],
    //          clear_mask[132:129], zero pad
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,
    // s_tuser: func[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: sensor_index[1:0], point_x[22:2], point_y[43:23], slot[49:44], zero pad
    output logic [55:0]  m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    localparam int NS = rbg_pkg::NUM_SENSORS;

    function automatic logic [rbg_pkg::SINE_AW-1:0] quad_addr(input logic [15:0] a);
        return a[14] ? rbg_pkg::SINE_LAST - {1'b0, a[13:0]} : {1'b0, a[13:0]};
    endfunction

    // Round |range*trig| to mm, apply sign, add pose, saturate to 21 bits
    function automatic logic [20:0] point_coord(input logic [30:0] mag,
                                                input logic        neg,
                                                input logic [19:0] pose);
        logic [30:0] rnd;
        logic [16:0] off;
        logic [21:0] sum;
        rnd = mag + 31'd16384;
        off = neg ? (17'd0 - {1'b0, rnd[30:15]}) : {1'b0, rnd[30:15]};
        sum = {{2{pose[19]}}, pose} + {{5{off[16]}}, off};
        if (sum[21] != sum[20])
        begin
            return sum[21] ? 21'h100000 : 21'h0FFFFF;
        end
        return sum[20:0];
    endfunction

    rbg_pkg::fill_t fill;

    logic [15:0] max_range_reg;

    // Input decode
    rbg_pkg::func_t in_func;
    logic [8:0]     in_servo;
    logic [15:0]    in_heading;
    logic [19:0]    in_pose_x;
    logic [19:0]    in_pose_y;
    logic [15:0]    in_rng [4];
    logic [3:0]     in_clear;
    logic [8:0]     servo_mag;
    logic [21:0]    bam_num;
    logic [44:0]    bam_prod;
    logic [15:0]    bam;
    logic [15:0]    base_next;
    logic [NS-1:0]  in_mask;
    logic           s_acc;

    // Held scan item
    logic          item_vld_reg;
    logic [NS-1:0] pend_reg;
    logic [15:0]   base_reg;
    logic [19:0]   pose_x_reg;
    logic [19:0]   pose_y_reg;
    logic [15:0]   range_reg [NS];

    logic [rbg_pkg::CNT_W-1:0] fc_reg [NS];

    // Issue stage
    logic                        adv;
    logic                        issue;
    logic [rbg_pkg::SENS_AW-1:0] k_idx;
    logic [NS-1:0]               low_bit;
    logic [NS-1:0]               pend_rest;
    logic [15:0]                 ang_s;
    logic [15:0]                 ang_c;
    logic [rbg_pkg::CNT_W-1:0]   cur_cnt;
    logic [rbg_pkg::CNT_W-1:0]   cnt_inc;
    logic                        cnt_full;
    logic [5:0]                  slot_sel;
    rbg_pkg::status_t            status_sel;

    logic [rbg_pkg::SINE_W-1:0] rd_cos;
    logic [rbg_pkg::SINE_W-1:0] rd_sin;

    logic             s1_vld_reg;
    logic [1:0]       s1_k_reg;
    logic [15:0]      s1_range_reg;
    logic [19:0]      s1_px_reg;
    logic [19:0]      s1_py_reg;
    logic [5:0]       s1_slot_reg;
    rbg_pkg::status_t s1_status_reg;
    logic             s1_last_reg;
    logic             s1_neg_c_reg;
    logic             s1_neg_s_reg;

    logic             s2_vld_reg;
    logic [1:0]       s2_k_reg;
    logic [19:0]      s2_px_reg;
    logic [19:0]      s2_py_reg;
    logic [5:0]       s2_slot_reg;
    rbg_pkg::status_t s2_status_reg;
    logic             s2_last_reg;
    logic             s2_neg_c_reg;
    logic             s2_neg_s_reg;
    logic [30:0]      s2_mag_x_reg;
    logic [30:0]      s2_mag_y_reg;

    logic             out_vld_reg;
    logic [1:0]       out_k_reg;
    logic [20:0]      out_x_reg;
    logic [20:0]      out_y_reg;
    logic [5:0]       out_slot_reg;
    rbg_pkg::status_t out_status_reg;
    logic             out_last_reg;

    rbg_sine_fill u_sine_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .fill  (fill)
    );

    rbg_ram #(
        .WIDTH (rbg_pkg::SINE_W),
        .DEPTH (rbg_pkg::SINE_DEPTH)
    ) u_sine_ram (
        .clk       (clk),
        .wr_en     (fill.wr_en),
        .wr_addr   (fill.addr),
        .wr_data   (fill.data),
        .rd_en     (adv),
        .rd_addr_a (quad_addr(ang_c)),
        .rd_data_a (rd_cos),
        .rd_addr_b (quad_addr(ang_s)),
        .rd_data_b (rd_sin)
    );

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= rbg_pkg::MAX_RANGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_range_reg <= cfg_data;
        end
    end

    // Input decode and base bearing
    always_comb
    begin
        in_func    = rbg_pkg::func_t'(s_tuser);
        in_servo   = s_tdata[8:0];
        in_heading = s_tdata[24:9];
        in_pose_x  = s_tdata[44:25];
        in_pose_y  = s_tdata[64:45];
        in_rng[0]  = s_tdata[80:65];
        in_rng[1]  = s_tdata[96:81];
        in_rng[2]  = s_tdata[112:97];
        in_rng[3]  = s_tdata[128:113];
        in_clear   = s_tdata[132:129];

        // round(|deg| * 65536 / 360): (|deg|*65536 + 180) / 8 / 45
        servo_mag = in_servo[8] ? (9'd0 - in_servo) : in_servo;
        bam_num   = {servo_mag, 13'd0} + 22'd22;
        bam_prod  = 45'(bam_num) * 45'(rbg_pkg::RECIP_45);
        bam       = in_servo[8] ? (16'd0 - bam_prod[43:28]) : bam_prod[43:28];
        base_next = bam + in_heading + 16'h8000;

        for (int i = 0; i < NS; i++)
        begin
            in_mask[i] = (in_rng[i] != 16'd0) && (in_rng[i] <= max_range_reg);
        end
    end

    // Issue stage: lowest pending sensor, its angle and buffer slot
    always_comb
    begin
        adv       = !out_vld_reg || m_tready;
        issue     = item_vld_reg && adv;
        low_bit   = pend_reg & (~pend_reg + 1'b1);
        pend_rest = pend_reg & ~low_bit;
        k_idx     = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                k_idx = rbg_pkg::SENS_AW'(i);
            end
        end
        ang_s    = base_reg + {2'(k_idx), 14'd0};
        ang_c    = ang_s + 16'h4000;
        cur_cnt  = fc_reg[k_idx];
        cnt_full = (cur_cnt == rbg_pkg::CNT_W'(rbg_pkg::BUFFER_POINTS));
        cnt_inc  = cur_cnt + 1'b1;
        priority if (cnt_full)
        begin
            slot_sel   = 6'd0;
            status_sel = rbg_pkg::ST_DROPPED;
        end
        else if (cnt_inc == rbg_pkg::CNT_W'(rbg_pkg::BUFFER_POINTS))
        begin
            slot_sel   = 6'(cur_cnt);
            status_sel = rbg_pkg::ST_FULL;
        end
        else
        begin
            slot_sel   = 6'(cur_cnt);
            status_sel = rbg_pkg::ST_STORED;
        end
    end

    assign s_tready = fill.done && (!item_vld_reg || (issue && (pend_rest == '0)));
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else if (s_acc && (in_func == rbg_pkg::FUNC_SCAN) && (in_mask != '0))
        begin
            item_vld_reg <= 1'b1;
            pend_reg     <= in_mask;
        end
        else if (issue)
        begin
            pend_reg <= pend_rest;
            if (pend_rest == '0)
            begin
                item_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            base_reg   <= base_next;
            pose_x_reg <= in_pose_x;
            pose_y_reg <= in_pose_y;
            for (int i = 0; i < NS; i++)
            begin
                range_reg[i] <= in_rng[i];
            end
        end
    end

    // Fill counts: a clear beat in the same cycle as an issue wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                fc_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (s_acc && (in_func == rbg_pkg::FUNC_CLEAR) && in_clear[i])
                begin
                    fc_reg[i] <= '0;
                end
                else if (issue && (k_idx == rbg_pkg::SENS_AW'(i)) && !cnt_full)
                begin
                    fc_reg[i] <= cnt_inc;
                end
            end
        end
    end

    // Point pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= issue;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_k_reg      <= 2'(k_idx);
            s1_range_reg  <= range_reg[k_idx];
            s1_px_reg     <= pose_x_reg;
            s1_py_reg     <= pose_y_reg;
            s1_slot_reg   <= slot_sel;
            s1_status_reg <= status_sel;
            s1_last_reg   <= (pend_rest == '0);
            s1_neg_c_reg  <= ang_c[15];
            s1_neg_s_reg  <= ang_s[15];

            s2_k_reg      <= s1_k_reg;
            s2_px_reg     <= s1_px_reg;
            s2_py_reg     <= s1_py_reg;
            s2_slot_reg   <= s1_slot_reg;
            s2_status_reg <= s1_status_reg;
            s2_last_reg   <= s1_last_reg;
            s2_neg_c_reg  <= s1_neg_c_reg;
            s2_neg_s_reg  <= s1_neg_s_reg;
            s2_mag_x_reg  <= 31'(s1_range_reg) * 31'(rd_cos);
            s2_mag_y_reg  <= 31'(s1_range_reg) * 31'(rd_sin);

            out_k_reg      <= s2_k_reg;
            out_x_reg      <= point_coord(s2_mag_x_reg, s2_neg_c_reg, s2_px_reg);
            out_y_reg      <= point_coord(s2_mag_y_reg, s2_neg_s_reg, s2_py_reg);
            out_slot_reg   <= s2_slot_reg;
            out_status_reg <= s2_status_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_slot_reg, out_y_reg, out_x_reg, out_k_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/rbg_checker.sv
// Port-level checks on the point stream, bound to the top level.
`include "assert_macros.svh"

module rbg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Hold the whole beat while the receiver stalls
    `RBG_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // A dropped point reports slot zero
    `RBG_ASSERT_IMP(a_drop_slot, clk, rst_n, m_tvalid && (m_tuser == rbg_pkg::ST_DROPPED), m_tdata[49:44] == 6'd0)

    // The point that fills a buffer takes its last slot
    `RBG_ASSERT_IMP(a_full_slot, clk, rst_n, m_tvalid && (m_tuser == rbg_pkg::ST_FULL), m_tdata[49:44] == 6'(rbg_pkg::BUFFER_POINTS - 1))

    // Only configured sensors produce points
    `RBG_ASSERT_IMP(a_sensor_idx, clk, rst_n, m_tvalid, m_tdata[1:0] <= 2'(rbg_pkg::NUM_SENSORS - 1))

endmodule

bind range_bearing_to_global_points rbg_checker u_rbg_checker (.*);
